>>> sv/ete_pkg.sv
// shared types, constants and table builder for the exponential easing tween
// used by ete_div, ete_blend and exponential_easing_tween_top; no dependencies
package ete_pkg;

  localparam int QUO_BITS = 20;   // exponent magnitude, unsigned Q4.16
  localparam int ALPHA_W  = 18;   // alpha, Q16 in [0, 2^17]
  localparam int NUM_AXES = 3;

  localparam logic [1:0] MODE_IN  = 2'd0;
  localparam logic [1:0] MODE_OUT = 2'd1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
  localparam logic [ALPHA_W-1:0] ALPHA_TWO = ALPHA_W'(131072);

  typedef enum logic [2:0] {
    REG_MODE,
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_END_X,
    REG_END_Y,
    REG_END_Z,
    REG_DURATION
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ALPHA,
    ST_BLEND,
    ST_OUT
  } st_t;

  typedef enum logic [1:0] {
    PICK_BLEND,
    PICK_START,
    PICK_END
  } pick_t;

  typedef struct packed {
    logic go;     // latch alpha and start the three-axis pass
    logic half;   // shift by 17 instead of 16 (ease in/out)
  } blend_req_t;

  // integer square root, bit by bit
  function automatic longint unsigned isqrt64(input longint unsigned val);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = val;
    r = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // entry k of the 2^(-k / 2^etb) table in Q16, evaluated at elaboration
  function automatic logic [16:0] exp_entry(input int k, input int etb);
    longint unsigned fac [10];
    longint unsigned v;
    longint unsigned acc;
    v = 64'd1 << 31;
    for (int j = 0; j < 10; j++) begin
      fac[j] = 0;
      if (j < etb) begin
        v = isqrt64(v << 32);
        fac[j] = v;
      end
    end
    acc = 64'd1 << 32;
    for (int j = 0; j < 10; j++) begin
      if (j < etb && ((k >> (etb - 1 - j)) & 1) != 0) begin
        acc = (acc * fac[j] + (64'd1 << 31)) >> 32;
      end
    end
    return 17'((acc + 64'd32768) >> 16);
  endfunction

endpackage

>>> sv/ete_div.sv
// restoring divider, one quotient bit per cycle: quo = floor(num * 2^16 / den)
// depends on ete_pkg; caller guarantees the quotient fits in QUO_BITS
module ete_div #(
  parameter int TIME_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [TIME_BITS+3:0] num,
  input  logic [TIME_BITS-1:0] den,
  output logic                 done,
  output logic [ete_pkg::QUO_BITS-1:0] quo
);
  import ete_pkg::*;

  localparam int CNT_W = $clog2(QUO_BITS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] dvs;
  logic [QUO_BITS-1:0]  shf;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   diff;
  logic                 fits;

  assign trial = {rem, shf[QUO_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !go && busy && (cnt == CNT_W'(1));
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // numerator above the low four bits is already below den
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= num[TIME_BITS+3:4];
      shf <= {num[3:0], (QUO_BITS-4)'(0)};
      dvs <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      shf <= {shf[QUO_BITS-2:0], 1'b0};
      quo <= {quo[QUO_BITS-2:0], fits};
    end
  end

endmodule

>>> sv/ete_blend.sv
// shared multiplier pass over the three axes: pos = start + round(diff * alpha / 2^s)
// depends on ete_pkg; each axis takes a multiply step, then a round and add step
module ete_blend #(
  parameter int POS_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ete_pkg::blend_req_t          req,
  input  logic [ete_pkg::ALPHA_W-1:0]  alpha_in,
  input  logic signed [POS_BITS-1:0]   start_pos [ete_pkg::NUM_AXES],
  input  logic signed [POS_BITS-1:0]   end_pos   [ete_pkg::NUM_AXES],
  output logic                         done,
  output logic signed [POS_BITS-1:0]   res       [ete_pkg::NUM_AXES]
);
  import ete_pkg::*;

  localparam int PW = POS_BITS + ALPHA_W + 2;
  localparam logic [1:0] AXIS_LAST = 2'(NUM_AXES - 1);

  logic                      busy;
  logic                      phase;
  logic [1:0]                axis;
  logic [ALPHA_W-1:0]        alpha;
  logic                      half;
  logic signed [PW-1:0]      prod;
  logic signed [POS_BITS:0]  diff;
  logic signed [ALPHA_W:0]   alpha_s;
  logic signed [PW-1:0]      prod_c;
  logic signed [PW-1:0]      rnd;
  logic signed [PW-1:0]      q;
  logic signed [PW-1:0]      shifted;

  assign diff    = {end_pos[axis][POS_BITS-1], end_pos[axis]}
                 - {start_pos[axis][POS_BITS-1], start_pos[axis]};
  assign alpha_s = {1'b0, alpha};
  assign prod_c  = PW'(diff) * PW'(alpha_s);

  // round half up, then floor by arithmetic shift
  assign rnd     = half ? (PW'(1) <<< 16) : (PW'(1) <<< 15);
  assign q       = prod + rnd;
  assign shifted = half ? (q >>> 17) : (q >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      axis  <= '0;
    end else begin
      done <= !req.go && busy && phase && (axis == AXIS_LAST);
      if (req.go) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        axis  <= '0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          if (axis == AXIS_LAST) begin
            busy <= 1'b0;
          end else begin
            axis <= axis + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      alpha <= alpha_in;
      half  <= req.half;
    end
    if (busy && !phase) begin
      prod <= prod_c;
    end
    if (busy && phase) begin
      res[axis] <= start_pos[axis] + shifted[POS_BITS-1:0];
    end
  end

endmodule

>>> sv/exponential_easing_tween_top.sv
// exponential easing tween, top level: config registers, sequencer, output stage
// depends on ete_pkg, ete_div and ete_blend
//
//  channel  | signals                              | direction | moves
//  ---------+--------------------------------------+-----------+------------------------------
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data| in       | register write request
//  s        | s_tvalid s_tready s_tdata s_tuser     | in        | tick or restart request
//  m        | m_tvalid m_tready m_tdata m_tlast     | out       | position result, tlast=finished
//
// a restart, or a tick while stopped, yields no result and leaves the sequencer idle.
// a tick that passes the duration, or lands on the start (not in ease out) or the end
// (not in ease in), goes from ST_PREP straight to ST_OUT; any other tick runs the divider's
// 20 quotient bits (one per cycle) and then the shared multiplier over three axes.
// s_tready is high only in idle; a finished result sits in the output register,
// so the next request is taken while m_tready is low. reset is synchronous and
// clears the registers to mode ease in, positions 0, duration 1, stopped.
module exponential_easing_tween_top #(
  parameter int TIME_BITS      = 24,
  parameter int POS_BITS       = 24,
  parameter int EXP_TABLE_BITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [((POS_BITS > TIME_BITS) ? POS_BITS : TIME_BITS)-1:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] step_time
  input  logic        s_tuser,   // [0] kind: 0 tick, 1 restart
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [((3*POS_BITS+7)/8)*8-1:0] m_tdata, // pos_x, pos_y, pos_z, zero pad
  output logic        m_tlast    // finished
);
  import ete_pkg::*;

  localparam int OUT_W    = ((3 * POS_BITS + 7) / 8) * 8;
  localparam int TAB_SIZE = 1 << EXP_TABLE_BITS;
  localparam int SUM_W    = TIME_BITS + 17;

  // configuration registers
  logic [1:0]                ease_mode;
  logic signed [POS_BITS-1:0] start_pos [NUM_AXES];
  logic signed [POS_BITS-1:0] end_pos   [NUM_AXES];
  logic [TIME_BITS-1:0]      duration;

  // motion state
  logic [TIME_BITS-1:0]      elapsed;
  logic                      running;

  // sequencer
  st_t                       state;
  st_t                       state_next;
  pick_t                     pick;
  logic                      fin;
  logic                      inv;
  logic                      half;

  // output stage
  logic signed [POS_BITS-1:0] out_pos [NUM_AXES];
  logic                      out_fin;

  // combinational
  logic                      accept;
  logic                      do_tick;
  logic [SUM_W-1:0]          sum;
  logic [TIME_BITS-1:0]      t_sat;
  logic [TIME_BITS-1:0]      d_eff;
  logic                      mode_io;
  logic                      over;
  logic                      lt_half;
  logic [TIME_BITS:0]        t2;
  logic [TIME_BITS:0]        n_io;
  logic [TIME_BITS-1:0]      n;
  logic [TIME_BITS+3:0]      num10;
  pick_t                     pick_c;
  logic                      div_go;
  logic                      div_done;
  logic [QUO_BITS-1:0]       quo;
  logic [16:0]               exp_tab [TAB_SIZE];
  logic [16:0]               p;
  logic [ALPHA_W-1:0]        base;
  logic [ALPHA_W-1:0]        alpha_c;
  blend_req_t                breq;
  logic                      blend_done;
  logic signed [POS_BITS-1:0] blend_res [NUM_AXES];
  logic                      out_free;
  logic                      load_out;

  // 2^-frac table, built at elaboration
  for (genvar k = 0; k < TAB_SIZE; k++) begin : g_tab
    assign exp_tab[k] = exp_entry(k, EXP_TABLE_BITS);
  end

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign do_tick   = accept && !s_tuser && running;

  // saturating elapsed-time update
  assign sum   = SUM_W'(elapsed) + SUM_W'(s_tdata);
  assign t_sat = ((sum >> TIME_BITS) != '0) ? '1 : sum[TIME_BITS-1:0];

  // classify the tick and pick the exponent numerator
  assign d_eff   = (duration == '0) ? TIME_BITS'(1) : duration;
  assign mode_io = (ease_mode != MODE_IN) && (ease_mode != MODE_OUT);
  assign over    = elapsed > d_eff;
  assign t2      = {elapsed, 1'b0};
  assign lt_half = t2 < {1'b0, d_eff};
  assign n_io    = lt_half ? ({1'b0, d_eff} - t2) : (t2 - {1'b0, d_eff});

  always_comb begin
    if (ease_mode == MODE_IN) begin
      n = d_eff - elapsed;
    end else if (ease_mode == MODE_OUT) begin
      n = elapsed;
    end else begin
      n = n_io[TIME_BITS-1:0];
    end
  end

  assign num10 = {1'b0, n, 3'b000} + {3'b000, n, 1'b0};

  always_comb begin
    pick_c = PICK_BLEND;
    if (over) begin
      pick_c = PICK_END;
    end else if (elapsed == '0 && ease_mode != MODE_OUT) begin
      pick_c = PICK_START;
    end else if (elapsed == d_eff && ease_mode != MODE_IN) begin
      pick_c = PICK_END;
    end
  end

  // alpha from quotient: table on the fraction, shift by the integer part
  assign p       = exp_tab[quo[15 -: EXP_TABLE_BITS]] >> quo[QUO_BITS-1:16];
  assign base    = half ? ALPHA_TWO : ALPHA_ONE;
  assign alpha_c = inv ? (base - {1'b0, p}) : {1'b0, p};

  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (do_tick) state_next = ST_PREP;
      ST_PREP:  state_next = (pick_c == PICK_BLEND) ? ST_DIV : ST_OUT;
      ST_DIV:   if (div_done) state_next = ST_ALPHA;
      ST_ALPHA: state_next = ST_BLEND;
      ST_BLEND: if (blend_done) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    div_go    = 1'b0;
    breq.go   = 1'b0;
    breq.half = half;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_PREP:  div_go = (pick_c == PICK_BLEND);
      ST_DIV:   ;
      ST_ALPHA: breq.go = 1'b1;
      ST_BLEND: ;
      ST_OUT:   load_out = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      running   <= 1'b0;
      elapsed   <= '0;
      ease_mode <= MODE_IN;
      duration  <= TIME_BITS'(1);
      for (int i = 0; i < NUM_AXES; i++) begin
        start_pos[i] <= '0;
        end_pos[i]   <= '0;
      end
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;

      // restart and tick requests
      if (accept && s_tuser) begin
        elapsed <= '0;
        running <= 1'b1;
      end else if (do_tick) begin
        elapsed <= t_sat;
      end
      if (state == ST_PREP && over) begin
        running <= 1'b0;
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MODE:     ease_mode    <= cfg_data[1:0];
          REG_START_X:  start_pos[0] <= cfg_data[POS_BITS-1:0];
          REG_START_Y:  start_pos[1] <= cfg_data[POS_BITS-1:0];
          REG_START_Z:  start_pos[2] <= cfg_data[POS_BITS-1:0];
          REG_END_X:    end_pos[0]   <= cfg_data[POS_BITS-1:0];
          REG_END_Y:    end_pos[1]   <= cfg_data[POS_BITS-1:0];
          REG_END_Z:    end_pos[2]   <= cfg_data[POS_BITS-1:0];
          REG_DURATION: duration     <= cfg_data[TIME_BITS-1:0];
          default:      ;
        endcase
      end

      // output register handshake
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // per-tick decisions and result payload
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      pick <= pick_c;
      fin  <= over;
      half <= mode_io;
      inv  <= (ease_mode == MODE_OUT) || (mode_io && !lt_half);
    end
    if (load_out) begin
      out_fin <= fin;
      for (int i = 0; i < NUM_AXES; i++) begin
        case (pick)
          PICK_START: out_pos[i] <= start_pos[i];
          PICK_END:   out_pos[i] <= end_pos[i];
          default:    out_pos[i] <= blend_res[i];
        endcase
      end
    end
  end

  assign m_tdata = OUT_W'({out_pos[2], out_pos[1], out_pos[0]});
  assign m_tlast = out_fin;

  ete_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (num10),
    .den  (d_eff),
    .done (div_done),
    .quo  (quo)
  );

  ete_blend #(
    .POS_BITS (POS_BITS)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .req       (breq),
    .alpha_in  (alpha_c),
    .start_pos (start_pos),
    .end_pos   (end_pos),
    .done      (blend_done),
    .res       (blend_res)
  );

endmodule

>>> tb/testbench.sv
// testbench for exponential_easing_tween_top: streams tick and restart requests, predicts
// every position with an independent fixed-point tween model and checks each result
// depends on ete_pkg and the rtl under sv/
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ete_pkg::*;

  localparam int TIME_W = 24;
  localparam int POS_W = 24;
  localparam int FRAC_BITS = 6;
  localparam longint unsigned TIME_TOP = (64'd1 << TIME_W) - 1;
  localparam logic [TIME_W-1:0] DUR_MAX = '1;
  localparam logic signed [POS_W-1:0] POS_LO = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_HI = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_RESTART = 1'b1;
  localparam logic [1:0] MODE_IN_OUT = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;   // undefined mode, acts as ease in/out
  localparam int SETTLE_CYCLES = 48;

  // one position result, laid out as {tlast, tdata}
  typedef struct packed {
    logic finished;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } tween_pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_MODE;
  logic [23:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;    // [15:0] step_time
  logic s_tuser = KIND_TICK;    // [0] kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [71:0] m_tdata;         // [23:0] pos_x, [47:24] pos_y, [71:48] pos_z
  logic m_tlast;                // finished

  // predicted block state, follows every accepted request and register write
  logic [1:0] tween_mode;
  logic signed [POS_W-1:0] tween_from [NUM_AXES];
  logic signed [POS_W-1:0] tween_to [NUM_AXES];
  logic [TIME_W-1:0] tween_duration;
  logic [TIME_W-1:0] tween_elapsed;
  logic tween_running;
  longint unsigned pow2_frac [1 << FRAC_BITS];   // 2^(-k/64) in Q16

  tween_pos_t pending_positions [$];

  bit idle_on = 1'b1;
  int hold_left = 0;
  int sent_requests = 0;
  int live_requests = 0;
  int restarts_sent = 0;
  int checked = 0;
  int finishes = 0;
  int setups = 0;
  int errors = 0;

  exponential_easing_tween_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // fraction table: repeated square roots of one half in Q32, multiplied per index bit
  initial begin : pow2_fill
    longint unsigned root_of [FRAC_BITS];
    longint unsigned rad;
    longint unsigned r;
    longint unsigned acc;
    rad = 64'd1 << 31;
    for (int j = 0; j < FRAC_BITS; j++) begin
      // floor square root of rad * 2^32, one result bit at a time
      rad = rad << 32;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= rad) r = r | (64'd1 << b);
      end
      root_of[j] = r;
      rad = r;
    end
    for (int k = 0; k < (1 << FRAC_BITS); k++) begin
      acc = 64'd1 << 32;
      for (int j = 0; j < FRAC_BITS; j++) begin
        if (((k >> (FRAC_BITS - 1 - j)) & 1) != 0) acc = (acc * root_of[j] + (64'd1 << 31)) >> 32;
      end
      pow2_frac[k] = (acc + 64'd32768) >> 16;
    end
  end

  // 2^-mag with mag in unsigned Q.16, index truncated, zero past 16 whole bits
  function automatic longint unsigned exp2_neg(input longint unsigned mag);
    if ((mag >> 16) > 16) return 0;
    return pow2_frac[(mag & 64'hFFFF) >> (16 - FRAC_BITS)] >> (mag >> 16);
  endfunction

  // start + diff*alpha/2^sh, rounded half up
  function automatic logic signed [POS_W-1:0] mix_axis(input logic signed [POS_W-1:0] from_p,
      input logic signed [POS_W-1:0] to_p, input longint unsigned alpha, input int sh);
    longint span;
    longint prod;
    span = longint'(to_p) - longint'(from_p);
    prod = span * longint'(alpha) + (longint'(1) << (sh - 1));
    return POS_W'(longint'(from_p) + (prod >>> sh));
  endfunction

  // apply one accepted request to the predicted state, queue the position it causes
  function automatic void advance_tween(input logic kind, input logic [15:0] step);
    longint unsigned t;
    longint unsigned d;
    longint unsigned alpha;
    int sh;
    pick_t pick;
    tween_pos_t res;
    logic signed [POS_W-1:0] axis [NUM_AXES];
    if (kind == KIND_RESTART) begin
      tween_elapsed = '0;
      tween_running = 1'b1;
      return;
    end
    // tick while stopped changes nothing
    if (!tween_running) return;
    t = tween_elapsed + step;
    if (t > TIME_TOP) t = TIME_TOP;
    tween_elapsed = TIME_W'(t);
    d = (tween_duration == 0) ? 1 : tween_duration;
    if (t > d) begin
      res = '{1'b1, tween_to[2], tween_to[1], tween_to[0]};
      tween_running = 1'b0;
      pending_positions.push_back(res);
      return;
    end
    alpha = 0;
    sh = 16;
    pick = PICK_BLEND;
    case (tween_mode)
      MODE_IN: begin
        if (t == 0) pick = PICK_START;
        else alpha = exp2_neg((((d - t) * 10) << 16) / d);
      end
      MODE_OUT: begin
        if (t >= d) pick = PICK_END;
        else alpha = ALPHA_ONE - exp2_neg(((t * 10) << 16) / d);
      end
      default: begin
        sh = 17;
        if (t == 0) pick = PICK_START;
        else if (t >= d) pick = PICK_END;
        else if (2 * t < d) alpha = exp2_neg((((d - 2 * t) * 10) << 16) / d);
        else alpha = ALPHA_TWO - exp2_neg((((2 * t - d) * 10) << 16) / d);
      end
    endcase
    for (int a = 0; a < NUM_AXES; a++) begin
      case (pick)
        PICK_START: axis[a] = tween_from[a];
        PICK_END: axis[a] = tween_to[a];
        default: axis[a] = mix_axis(tween_from[a], tween_to[a], alpha, sh);
      endcase
    end
    res = '{1'b0, axis[2], axis[1], axis[0]};
    pending_positions.push_back(res);
  endfunction

  function automatic logic signed [POS_W-1:0] random_pos();
    case ($urandom_range(0, 9))
      0: return POS_LO;
      1: return POS_HI;
      2: return '0;
      default: return POS_W'($urandom);
    endcase
  endfunction

  // one register write request; cfg_valid stays up for the next write
  task automatic put_register(input cfg_reg_t idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE: tween_mode = value[1:0];
      REG_START_X: tween_from[0] = value;
      REG_START_Y: tween_from[1] = value;
      REG_START_Z: tween_from[2] = value;
      REG_END_X: tween_to[0] = value;
      REG_END_Y: tween_to[1] = value;
      REG_END_Z: tween_to[2] = value;
      default: tween_duration = value;
    endcase
  endtask

  // write every register, only called with the block idle
  task automatic load_setup(input logic [1:0] mode,
      input logic signed [POS_W-1:0] from_x, input logic signed [POS_W-1:0] from_y,
      input logic signed [POS_W-1:0] from_z, input logic signed [POS_W-1:0] to_x,
      input logic signed [POS_W-1:0] to_y, input logic signed [POS_W-1:0] to_z,
      input logic [TIME_W-1:0] dur);
    put_register(REG_MODE, 24'(mode));
    put_register(REG_START_X, from_x);
    put_register(REG_START_Y, from_y);
    put_register(REG_START_Z, from_z);
    put_register(REG_END_X, to_x);
    put_register(REG_END_Y, to_y);
    put_register(REG_END_Z, to_z);
    put_register(REG_DURATION, dur);
    cfg_valid <= 1'b0;
    setups++;
  endtask

  // offer one request, with an occasional idle burst in front of it
  task automatic send_request(input logic kind, input logic [15:0] step);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    sent_requests++;
    if (kind == KIND_RESTART) restarts_sent++;
    if (kind == KIND_RESTART || tween_running) live_requests++;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= step;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_tween(kind, step);
  endtask

  // sender pauses until every queued position has come, then lets the
  // block finish any request that yields no result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // restart, then tick with steps scaled to the duration until the motion stops or 40 requests are sent
  task automatic run_motion(input logic [TIME_W-1:0] dur);
    int stride;
    int ticks;
    stride = (dur > 4 * 65535) ? 65535 : (dur / 4) + 1;
    send_request(KIND_RESTART, 16'($urandom));
    ticks = 0;
    while (tween_running && ticks < 40) begin
      ticks++;
      case ($urandom_range(0, 15))
        0: send_request(KIND_TICK, 16'($urandom));
        1: send_request(KIND_TICK, 16'd0);
        2: send_request(KIND_RESTART, 16'($urandom));   // restart mid motion
        default: send_request(KIND_TICK, 16'($urandom_range(0, stride)));
      endcase
    end
    // sometimes one more tick, ignored if the motion has stopped
    if ($urandom_range(0, 3) == 0) send_request(KIND_TICK, 16'($urandom));
  endtask

  // defaults after reset: ease in, positions 0, duration 1, stopped
  task automatic test_reset_defaults();
    send_request(KIND_TICK, 16'd5);        // stopped, no result
    send_request(KIND_RESTART, 16'hFFFF);  // step is ignored on a restart
    send_request(KIND_TICK, 16'd0);        // ease in at zero elapsed gives start
    send_request(KIND_TICK, 16'd1);        // elapsed equals duration
    send_request(KIND_TICK, 16'd1);        // past the end, finished
    drain_results();
  endtask

  // extreme positions, each mode at zero, halfway, exact end and past the end
  task automatic test_mode_endpoints();
    logic [1:0] mode_list [3];
    mode_list = '{MODE_IN, MODE_OUT, MODE_IN_OUT};
    foreach (mode_list[i]) begin
      load_setup(mode_list[i], POS_LO, POS_HI, '0, POS_HI, POS_LO, POS_W'($urandom), 24'd8);
      send_request(KIND_RESTART, 16'd0);
      send_request(KIND_TICK, 16'd0);
      send_request(KIND_TICK, 16'd4);
      send_request(KIND_TICK, 16'd4);
      send_request(KIND_TICK, 16'hFFFF);
      drain_results();
    end
    load_setup(MODE_SPARE, POS_HI, POS_LO, random_pos(), POS_LO, POS_HI, random_pos(), 24'd8);
    send_request(KIND_RESTART, 16'd0);
    send_request(KIND_TICK, 16'd3);
    send_request(KIND_TICK, 16'hFFFF);
    drain_results();
  endtask

  // zero duration acts as one
  task automatic test_zero_duration();
    load_setup(MODE_OUT, random_pos(), random_pos(), random_pos(),
               random_pos(), random_pos(), random_pos(), 24'd0);
    send_request(KIND_RESTART, 16'd0);
    send_request(KIND_TICK, 16'd0);
    send_request(KIND_TICK, 16'd1);
    send_request(KIND_TICK, 16'd1);
    drain_results();
  endtask

  // largest duration: elapsed time saturates at the top and the motion never ends
  task automatic test_elapsed_saturation();
    load_setup(MODE_OUT, random_pos(), random_pos(), random_pos(),
               random_pos(), random_pos(), random_pos(), DUR_MAX);
    send_request(KIND_RESTART, 16'd0);
    repeat (258) send_request(KIND_TICK, 16'hFFFF);
    drain_results();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    load_setup(MODE_IN_OUT, random_pos(), random_pos(), random_pos(),
               random_pos(), random_pos(), random_pos(), 24'd1000);
    send_request(KIND_RESTART, 16'd0);
    hold_left = 600;
    repeat (24) send_request(KIND_TICK, 16'($urandom_range(1, 60)));
    drain_results();
  endtask

  // random setups, each followed by a few random motions
  task automatic test_random_motions(input int target);
    int goal;
    logic [1:0] mode;
    logic [TIME_W-1:0] dur;
    logic signed [POS_W-1:0] fx;
    logic signed [POS_W-1:0] fy;
    logic signed [POS_W-1:0] fz;
    logic same_ends;
    goal = live_requests + target;
    while (live_requests < goal) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: mode = MODE_SPARE;
        1, 2, 3: mode = MODE_IN;
        4, 5, 6: mode = MODE_OUT;
        default: mode = MODE_IN_OUT;
      endcase
      case ($urandom_range(0, 11))
        0: dur = '0;
        1: dur = DUR_MAX;
        2: dur = TIME_W'($urandom);
        3, 4: dur = TIME_W'($urandom_range(1, 8));
        default: dur = TIME_W'($urandom_range(9, 400));
      endcase
      fx = random_pos();
      fy = random_pos();
      fz = random_pos();
      same_ends = ($urandom_range(0, 7) == 0);
      load_setup(mode, fx, fy, fz, same_ends ? fx : random_pos(),
                 same_ends ? fy : random_pos(), same_ends ? fz : random_pos(), dur);
      repeat ($urandom_range(1, 4)) run_motion(dur);
      drain_results();
    end
  endtask

  // closing stretch with both sides running flat out
  task automatic test_quiet_finish();
    idle_on = 1'b0;
    load_setup(MODE_IN_OUT, random_pos(), random_pos(), random_pos(),
               random_pos(), random_pos(), random_pos(), TIME_W'($urandom_range(50, 300)));
    repeat (6) run_motion(tween_duration);
    drain_results();
  endtask

  // result side: long hold-off when asked, else random stall bursts while idle_on is set
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 18);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // every accepted position against the oldest prediction
  always @(posedge clk) begin : position_check
    tween_pos_t want;
    tween_pos_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata[3*POS_W-1:0]};
      if (got.finished) finishes++;
      if (pending_positions.size() == 0) begin
        $display("%0t: position x=%0d y=%0d z=%0d finished=%0b with nothing expected",
                 $time, got.pos_x, got.pos_y, got.pos_z, got.finished);
        errors++;
      end else begin
        want = pending_positions.pop_front();
        checked++;
        if (got.pos_x !== want.pos_x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, got.pos_x);
          errors++;
        end
        if (got.pos_y !== want.pos_y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, got.pos_y);
          errors++;
        end
        if (got.pos_z !== want.pos_z) begin
          $display("%0t: pos_z expected %0d actual %0d", $time, want.pos_z, got.pos_z);
          errors++;
        end
        if (got.finished !== want.finished) begin
          $display("%0t: finished expected %0b actual %0b", $time, want.finished, got.finished);
          errors++;
        end
      end
    end
  end

  initial begin
    tween_mode = MODE_IN;
    for (int a = 0; a < NUM_AXES; a++) begin
      tween_from[a] = '0;
      tween_to[a] = '0;
    end
    tween_duration = 1;
    tween_elapsed = '0;
    tween_running = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_mode_endpoints();
    test_zero_duration();
    test_elapsed_saturation();
    test_output_backpressure();
    test_random_motions(1330);
    test_quiet_finish();
    $display("tween run: %0d requests (%0d restarts), %0d positions checked, %0d motion ends",
             sent_requests, restarts_sent, checked, finishes);
    $display("  %0d register setups over all ease modes, zero to top duration, saturated time",
             setups);
    if (errors == 0) begin
      $display("exponential_easing_tween_top verification clean");
    end else begin
      $display("exponential_easing_tween_top verification failed");
    end
    $finish;
  end

  // hard limit, many times the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("exponential_easing_tween_top verification failed");
    $finish;
  end

endmodule
